@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of one property.
`define TCW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in this cycle implies a result in the next cycle.
`define TCW_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ hw/rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, codes and defaults of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 4;

   localparam logic [CSR_ADDR_W-1:0] CSR_BG_COLOR = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FG_COLOR = 2'd1;

   localparam logic [3:0] BG_RESET = 4'h0;
   localparam logic [3:0] FG_RESET = 4'hF;

   localparam logic [1:0] KIND_PUT   = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   localparam logic [15:0] RESET_CELL = 16'h0F20;
   localparam int          TAB_STOP   = 8;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [15:0] cell_word;
      logic        scrolled;
   } rsp_type;

endpackage

@@ hw/rtl/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: character-cell screen memory with cursor, put, clear
// and read commands, and foreground/background color registers.
// ----------------------------------------------------------------------------
//  channel   dir   handshake             word
//  req       in    req_valid/req_ready   tcw_pkg::req_type
//  rsp       out   rsp_valid/rsp_ready   tcw_pkg::rsp_type
//  csr       in    csr_valid/csr_ready   csr_index, csr_data
//
//  A put writes its cell when it is accepted; a read uses a registered memory read.
//  Clear and scroll walk the screen memory one cell a cycle through the single
//  write port. After reset a clearing pass over every cell holds req_ready low.
//  A stalled rsp keeps one word in the output register and one in the engine.
// ----------------------------------------------------------------------------
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  tcw_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output tcw_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] csr_data
);

   logic [3:0]       bg_ff, bg_in;
   logic [3:0]       fg_ff, fg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic             res_valid, res_take;
   tcw_pkg::rsp_type res_data;

   tcw_engine #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .attr      ({bg_ff, fg_ff}),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_data  (res_data)
   );

   assign csr_ready = 1'b1;
   assign res_take  = res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      bg_in = bg_ff;
      fg_in = fg_ff;
      if (csr_valid) begin
         case (csr_index)
            tcw_pkg::CSR_BG_COLOR: bg_in = csr_data[3:0];
            tcw_pkg::CSR_FG_COLOR: fg_in = csr_data[3:0];
            default: ;
         endcase
      end
      rsp_data_in  = res_take ? res_data : rsp_data_ff;
      rsp_valid_in = res_take || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff        <= tcw_pkg::BG_RESET;
         fg_ff        <= tcw_pkg::FG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         bg_ff        <= bg_in;
         fg_ff        <= fg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hw/rtl/tcw_engine.sv @@
// ----------------------------------------------------------------------------
// tcw_engine
// Screen memory, cursor update and the sequencer for read, clear and scroll.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_engine #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcw_pkg::req_type req_data,
   input  logic [7:0]       attr,
   output logic             res_valid,
   input  logic             res_take,
   output tcw_pkg::rsp_type res_data
);

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int CT_W       = $clog2(COLUMNS + tcw_pkg::TAB_STOP);
   localparam int RT_W       = $clog2(ROWS + 1);

   localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELL_COUNT - 1);
   localparam logic [ADDR_W-1:0] COPY_LAST   = ADDR_W'((ROWS - 1) * COLUMNS - 1);
   localparam logic [ADDR_W-1:0] BLANK_FIRST = ADDR_W'((ROWS - 1) * COLUMNS);

   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_READ  = 7'b0000100,
      ST_COPY  = 7'b0001000,
      ST_FLUSH = 7'b0010000,
      ST_BLANK = 7'b0100000,
      ST_HOLD  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic [15:0]       fill_ff, fill_in;
   logic [15:0]       word_ff, word_in;
   logic              scr_ff, scr_in;
   logic              oor_ff, oor_in;
   logic              cp_pend_ff, cp_pend_in;
   logic [ADDR_W-1:0] cp_addr_ff, cp_addr_in;

   logic [15:0]       mem [CELL_COUNT];
   logic [15:0]       rd_data_ff;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [15:0]       wr_data;

   logic [CT_W-1:0]   ct;
   logic [RT_W-1:0]   rt;
   logic              put_we, put_scroll;
   logic [COL_W-1:0]  put_col;
   logic [ROW_W-1:0]  put_row;
   logic [15:0]       put_word, blank_word;
   logic [ADDR_W-1:0] put_addr;

   assign blank_word = {attr, tcw_pkg::CH_SPACE};

   always_comb begin
      ct       = CT_W'(col_ff);
      rt       = RT_W'(row_ff);
      put_we   = 1'b0;
      put_col  = col_ff;
      put_word = blank_word;
      if (req_data.char_code == tcw_pkg::CH_BS && col_ff != '0) begin
         ct      = ct - CT_W'(1);
         put_col = col_ff - COL_W'(1);
         put_we  = 1'b1;
      end else if (req_data.char_code == tcw_pkg::CH_TAB) begin
         ct = (ct + CT_W'(tcw_pkg::TAB_STOP)) & ~CT_W'(tcw_pkg::TAB_STOP - 1);
      end else if (req_data.char_code == tcw_pkg::CH_CR) begin
         ct = '0;
      end else if (req_data.char_code == tcw_pkg::CH_LF) begin
         ct = '0;
         rt = rt + RT_W'(1);
      end else if (req_data.char_code >= tcw_pkg::CH_SPACE &&
                   req_data.char_code < tcw_pkg::CH_DEL) begin
         put_we   = 1'b1;
         put_word = {attr, req_data.char_code};
         ct       = ct + CT_W'(1);
      end
      if (ct >= CT_W'(COLUMNS)) begin
         ct = '0;
         rt = rt + RT_W'(1);
      end
      put_scroll = (rt >= RT_W'(ROWS));
      put_row    = put_scroll ? ROW_W'(ROWS - 1) : rt[ROW_W-1:0];
   end

   assign put_addr = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(put_col);

   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      ptr_in     = ptr_ff;
      fill_in    = fill_ff;
      word_in    = word_ff;
      scr_in     = scr_ff;
      oor_in     = oor_ff;
      cp_pend_in = 1'b0;
      cp_addr_in = ptr_ff;
      wr_en      = 1'b0;
      wr_addr    = ptr_ff;
      wr_data    = fill_ff;
      rd_en      = 1'b0;
      rd_addr    = ptr_ff + ADDR_W'(COLUMNS);
      case (state_ff)
         ST_INIT: begin
            wr_en = 1'b1;
            if (ptr_ff == LAST_CELL) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               word_in = '0;
               scr_in  = 1'b0;
               fill_in = blank_word;
               ptr_in  = '0;
               case (req_data.kind)
                  tcw_pkg::KIND_PUT: begin
                     wr_en    = put_we;
                     wr_addr  = put_addr;
                     wr_data  = put_word;
                     col_in   = ct[COL_W-1:0];
                     row_in   = put_row;
                     scr_in   = put_scroll;
                     state_in = put_scroll ? ST_COPY : ST_HOLD;
                  end
                  tcw_pkg::KIND_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     state_in = ST_BLANK;
                  end
                  tcw_pkg::KIND_READ: begin
                     rd_en    = 1'b1;
                     rd_addr  = ADDR_W'(req_data.cell_index);
                     oor_in   = (32'(req_data.cell_index) >= CELL_COUNT);
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_HOLD;
                  end
               endcase
            end
         end
         ST_READ: begin
            word_in  = oor_ff ? '0 : rd_data_ff;
            state_in = ST_HOLD;
         end
         ST_COPY: begin
            rd_en      = 1'b1;
            cp_pend_in = 1'b1;
            wr_en      = cp_pend_ff;
            wr_addr    = cp_addr_ff;
            wr_data    = rd_data_ff;
            if (ptr_ff == COPY_LAST) begin
               state_in = ST_FLUSH;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         ST_FLUSH: begin
            wr_en    = 1'b1;
            wr_addr  = cp_addr_ff;
            wr_data  = rd_data_ff;
            ptr_in   = BLANK_FIRST;
            state_in = ST_BLANK;
         end
         ST_BLANK: begin
            wr_en = 1'b1;
            if (ptr_ff == LAST_CELL) begin
               ptr_in   = '0;
               state_in = ST_HOLD;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         ST_HOLD: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_INIT;
         col_ff     <= '0;
         row_ff     <= '0;
         ptr_ff     <= '0;
         fill_ff    <= tcw_pkg::RESET_CELL;
         cp_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         ptr_ff     <= ptr_in;
         fill_ff    <= fill_in;
         cp_pend_ff <= cp_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff    <= word_in;
      scr_ff     <= scr_in;
      oor_ff     <= oor_in;
      cp_addr_ff <= cp_addr_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign res_valid           = (state_ff == ST_HOLD);
   assign res_data.cursor_col = 7'(col_ff);
   assign res_data.cursor_row = 5'(row_ff);
   assign res_data.cell_word  = word_ff;
   assign res_data.scrolled   = scr_ff;

   `TCW_ASSERT(a_cursor_range, clock, reset, (32'(col_ff) < COLUMNS && 32'(row_ff) < ROWS), "cursor out of range")
   `TCW_ASSERT(a_copy_pend, clock, reset, (cp_pend_ff |-> (state_ff == ST_COPY || state_ff == ST_FLUSH)), "copy write outside scroll")
   `TCW_ASSERT(a_scroll_row, clock, reset, ((state_ff == ST_HOLD && scr_ff) |-> row_ff == ROW_W'(ROWS - 1)), "scroll left cursor off bottom row")
   `TCW_ASSERT_NEXT(a_hold_stall, clock, reset, (state_ff == ST_HOLD && !res_take), (state_ff == ST_HOLD), "result dropped while stalled")

endmodule

@@ test/text_console_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_checker
// Watches the command, result and register channels of the text console
// writer, keeps its own screen, cursor and colors, predicts the result word
// of every accepted command and compares it against the returned words.
// ----------------------------------------------------------------------------
module text_console_checker #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  tcw_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  tcw_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [tcw_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] csr_data,
   output int                             fail_count,
   output int                             pending_words,
   output int                             scroll_count,
   output int                             read_count
);
   import tcw_pkg::*;

   localparam int CELLS       = COLUMNS * ROWS;
   localparam int MAX_REPORTS = 10;

   logic [15:0] screen [CELLS];
   int          col_at;
   int          row_at;
   logic [3:0]  bg_nib;
   logic [3:0]  fg_nib;
   rsp_type     awaited_q [$];

   task automatic log_fault(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
         $display("%s", msg);
      end
   endtask

   task automatic scroll_screen(input logic [15:0] blank);
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
         screen[i] = screen[i + COLUMNS];
      end
      for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
         screen[i] = blank;
      end
      row_at = ROWS - 1;
   endtask

   task automatic run_command(input req_type w, output rsp_type r);
      logic [15:0] blank;
      logic [15:0] cell_val;
      logic        scr;
      blank    = {bg_nib, fg_nib, CH_SPACE};
      cell_val = '0;
      scr      = 1'b0;
      case (w.kind)
         KIND_PUT: begin
            if (w.char_code == CH_BS) begin
               if (col_at != 0) begin
                  col_at--;
                  screen[row_at * COLUMNS + col_at] = blank;
               end
            end else if (w.char_code == CH_TAB) begin
               col_at = (col_at + TAB_STOP) & ~(TAB_STOP - 1);
            end else if (w.char_code == CH_CR) begin
               col_at = 0;
            end else if (w.char_code == CH_LF) begin
               col_at = 0;
               row_at++;
            end else if (w.char_code >= CH_SPACE && w.char_code < CH_DEL) begin
               screen[row_at * COLUMNS + col_at] = {bg_nib, fg_nib, w.char_code};
               col_at++;
            end
            if (col_at >= COLUMNS) begin
               col_at = 0;
               row_at++;
            end
            if (row_at >= ROWS) begin
               scroll_screen(blank);
               scr = 1'b1;
            end
         end
         KIND_CLEAR: begin
            for (int i = 0; i < CELLS; i++) begin
               screen[i] = blank;
            end
            col_at = 0;
            row_at = 0;
         end
         KIND_READ: begin
            if (w.cell_index < CELLS) begin
               cell_val = screen[w.cell_index];
            end
         end
         default: ;
      endcase
      r.cursor_col = col_at[6:0];
      r.cursor_row = row_at[4:0];
      r.cell_word  = cell_val;
      r.scrolled   = scr;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < CELLS; i++) begin
            screen[i] = RESET_CELL;
         end
         col_at = 0;
         row_at = 0;
         bg_nib = BG_RESET;
         fg_nib = FG_RESET;
         awaited_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BG_COLOR) begin
               bg_nib = csr_data;
            end else if (csr_index == CSR_FG_COLOR) begin
               fg_nib = csr_data;
            end
         end
         if (req_valid && req_ready) begin
            run_command(req_data, want);
            awaited_q.push_back(want);
            if (want.scrolled) scroll_count++;
            if (req_data.kind == KIND_READ) read_count++;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_q.size() == 0) begin
               log_fault($sformatf("unexpected result word %h at %0t", rsp_data, $time));
            end else begin
               want = awaited_q.pop_front();
               if (rsp_data.cursor_col !== want.cursor_col ||
                   rsp_data.cursor_row !== want.cursor_row ||
                   rsp_data.cell_word  !== want.cell_word  ||
                   rsp_data.scrolled   !== want.scrolled) begin
                  log_fault($sformatf({"result mismatch at %0t: expected col %0d row %0d ",
                     "cell %h scrolled %0d, got col %0d row %0d cell %h scrolled %0d"},
                     $time, want.cursor_col, want.cursor_row, want.cell_word,
                     want.scrolled, rsp_data.cursor_col, rsp_data.cursor_row,
                     rsp_data.cell_word, rsp_data.scrolled));
               end
            end
         end
      end
      pending_words = awaited_q.size();
   end

endmodule

@@ test/text_console_writer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_test
// Drives put, clear, read and spare commands into the text console writer
// under random input gaps and output stalls, across several color settings,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module text_console_writer_test;
   import tcw_pkg::*;

   localparam int CELLS           = COLUMNS_DEF * ROWS_DEF;
   localparam int PHASES          = 6;
   localparam int PHASE_ITEMS     = 305;
   localparam int PRESSURE_CYCLES = 500;
   localparam int PRESSURE_WORDS  = 80;
   localparam int DRAIN_CYCLES    = 16;
   localparam int TIMEOUT_NS      = 100_000_000;

   localparam logic [1:0]            KIND_SPARE   = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_HI = 2'd3;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   int   fail_count;
   int   pending_words;
   int   scroll_count;
   int   read_count;
   int   sent_count = 0;
   logic hold_armed = 1'b0;
   logic hold_taken = 1'b0;

   always #4 clock = ~clock;

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   text_console_writer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   text_console_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .scroll_count  (scroll_count),
      .read_count    (read_count)
   );

   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_word(input logic [1:0] kind, input logic [7:0] code,
                            input logic [10:0] idx, input int gap);
      req_type w;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      w.kind       = kind;
      w.char_code  = code;
      w.cell_index = idx;
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_words != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // one line of text: mostly printable, some edits, usually ends in newline
   task automatic send_line(input bit dense);
      int         len;
      int         pick;
      logic [7:0] code;
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 20) : $urandom_range(60, 100);
      for (int n = 0; n < len; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) code = 8'($urandom_range(32, 126));
         else if (pick < 90) code = CH_BS;
         else if (pick < 95) code = CH_TAB;
         else code = 8'($urandom_range(0, 255));
         send_word(KIND_PUT, code, 11'($urandom_range(0, 2047)), dense ? 0 : pick_gap());
      end
      pick = $urandom_range(0, 99);
      if (pick >= 70 && pick < 85) begin
         send_word(KIND_PUT, CH_CR, 11'($urandom_range(0, 2047)), dense ? 0 : pick_gap());
      end
      if (pick < 85) begin
         send_word(KIND_PUT, CH_LF, 11'($urandom_range(0, 2047)), dense ? 0 : pick_gap());
      end
   endtask

   task automatic run_sequence();
      int pick;
      bit dense;
      pick  = $urandom_range(0, 99);
      dense = ($urandom_range(0, 3) == 0);
      if (pick < 60) begin
         send_line(dense);
      end else if (pick < 80) begin
         repeat ($urandom_range(1, 4)) begin
            send_word(KIND_READ, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)),
                      dense ? 0 : pick_gap());
         end
      end else if (pick < 97) begin
         repeat ($urandom_range(1, 3)) begin
            send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      11'($urandom_range(0, 2047)), dense ? 0 : pick_gap());
         end
      end else begin
         send_word(KIND_CLEAR, 8'($urandom_range(0, 255)), 11'($urandom_range(0, 2047)),
                   pick_gap());
      end
   endtask

   // output side: ready bursts, short and long stalls, one forced long hold
   initial begin
      int pick;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_armed && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               rsp_ready <= 1'b1;
               repeat ($urandom_range(1, 40)) @(posedge clock);
            end else if (pick < 93) begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(10, 60)) @(posedge clock);
            end
         end
      end
   end

   initial begin
      int         phase_end;
      logic [3:0] bg_val;
      logic [3:0] fg_val;
      do @(posedge clock); while (reset);

      send_word(KIND_READ, 8'h00, 11'd0, pick_gap());
      send_word(KIND_READ, 8'hFF, 11'(CELLS - 1), pick_gap());
      send_word(KIND_READ, 8'h00, 11'h7FF, pick_gap());
      send_word(KIND_PUT, 8'h41, 11'd0, pick_gap());
      send_word(KIND_PUT, 8'h7E, 11'd0, pick_gap());
      send_word(KIND_PUT, CH_SPACE, 11'd0, pick_gap());
      send_word(KIND_PUT, 8'h1F, 11'd0, pick_gap());
      send_word(KIND_PUT, CH_DEL, 11'd0, pick_gap());
      send_word(KIND_PUT, 8'hFF, 11'd0, pick_gap());
      send_word(KIND_PUT, CH_BS, 11'd0, pick_gap());
      send_word(KIND_PUT, CH_CR, 11'd0, pick_gap());
      send_word(KIND_PUT, CH_BS, 11'd0, pick_gap());
      repeat (10) send_word(KIND_PUT, CH_TAB, 11'd0, pick_gap());
      send_word(KIND_PUT, CH_LF, 11'd0, pick_gap());
      send_word(KIND_SPARE, 8'hFF, 11'h7FF, pick_gap());
      send_word(KIND_CLEAR, 8'h00, 11'd0, pick_gap());

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin bg_val = 4'hF; fg_val = 4'h0; end
            1: begin bg_val = 4'h0; fg_val = 4'hF; end
            2: begin bg_val = 4'hF; fg_val = 4'hF; end
            3: begin bg_val = 4'h0; fg_val = 4'h0; end
            default: begin
               bg_val = 4'($urandom_range(0, 15));
               fg_val = 4'($urandom_range(0, 15));
            end
         endcase
         write_reg(CSR_BG_COLOR, bg_val);
         write_reg(CSR_FG_COLOR, fg_val);
         if (p == 1) write_reg(CSR_SPARE_LO, 4'($urandom_range(0, 15)));
         if (p == 2) write_reg(CSR_SPARE_HI, 4'($urandom_range(0, 15)));
         phase_end = sent_count + PHASE_ITEMS;
         if (p == 0) begin
            hold_armed <= 1'b1;
            repeat (PRESSURE_WORDS) begin
               send_word(KIND_PUT, 8'($urandom_range(32, 126)), 11'($urandom_range(0, 2047)),
                         0);
            end
         end
         while (sent_count < phase_end) run_sequence();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      $display("Sent %0d commands over %0d color settings: %0d scrolls, %0d cell reads.",
               sent_count, PHASES + 1, scroll_count, read_count);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Regression FAIL");
      $finish;
   end

endmodule
